// File: rtl/mwm_pkg.sv
package mwm_pkg;

    // Field and register widths.
    localparam int LIM_W      = 15;
    localparam int RATIO_W    = 24;
    localparam int RPM_W      = 16;
    localparam int VEL_W      = 16;
    localparam int WHEELS     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Mixing arithmetic. A pair sum of clamped speeds needs 17 bits, the
    // Q16 wheel speed needs 41 bits and its magnitude stays below 2^40.
    localparam int SUM_W       = 17;
    localparam int ONE_SHIFT   = 16;
    localparam int MIX_W       = 41;
    localparam int MAG_W       = 40;
    localparam int RATIO_SPLIT = 12;
    localparam int PP_W        = MAG_W + RATIO_SPLIT;
    localparam int ACC_W       = PP_W + 1;
    localparam int RPM_SHIFT   = 28;

    // Proportional limiting.
    localparam int ABS_W     = RPM_W;
    localparam int PROD_W    = ABS_W + LIM_W;
    localparam int QUO_W     = LIM_W;
    localparam int DIV_STEPS = 3;
    localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

    localparam logic [RPM_W-1:0] RPM_MAX = 16'h7FFF;
    localparam logic [RPM_W-1:0] RPM_MIN = 16'h8000;

    // Wheel order of the result.
    localparam int WHEEL_FR = 0;
    localparam int WHEEL_FL = 1;
    localparam int WHEEL_BL = 2;
    localparam int WHEEL_BR = 3;

    // Register reset values.
    localparam logic [LIM_W-1:0]   RST_MAX_FORWARD = 15'd3300;
    localparam logic [LIM_W-1:0]   RST_MAX_LATERAL = 15'd3300;
    localparam logic [LIM_W-1:0]   RST_MAX_YAW     = 15'd300;
    localparam logic [LIM_W-1:0]   RST_MAX_RPM     = 15'd8500;
    localparam logic [RATIO_W-1:0] RST_ROTATE      = 24'd457469;
    localparam logic [RATIO_W-1:0] RST_RPM_RATIO   = 24'd110832;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FORWARD,
        CFG_MAX_LATERAL,
        CFG_MAX_YAW,
        CFG_MAX_RPM,
        CFG_ROTATE_RATIO,
        CFG_RPM_RATIO
    } cfg_index_t;

    typedef struct packed {
        logic [LIM_W-1:0]   max_forward;
        logic [LIM_W-1:0]   max_lateral;
        logic [LIM_W-1:0]   max_yaw;
        logic [LIM_W-1:0]   max_rpm;
        logic [RATIO_W-1:0] rotate_ratio;
        logic [RATIO_W-1:0] rpm_ratio;
    } cfg_t;

    typedef logic signed [RPM_W-1:0] rpm_t;
    typedef rpm_t [WHEELS-1:0] rpm_set_t;

    // Beat handed from the limit stages to the divider.
    typedef struct packed {
        rpm_set_t                       rpm;
        logic [WHEELS-1:0][PROD_W-1:0]  prod;
        logic [ABS_W-1:0]               max_mag;
        logic                           scaled;
    } lim_beat_t;

    typedef struct packed {
        rpm_set_t rpm;
        logic     scaled;
    } result_t;

endpackage

// File: rtl/mwm_mix.sv
module mwm_mix #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mwm_pkg::cfg_t                 cfg,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic signed [SPEED_WIDTH-1:0] forward_speed,
    input  logic signed [SPEED_WIDTH-1:0] lateral_speed,
    input  logic signed [SPEED_WIDTH-1:0] yaw_rate,
    output logic                          wheel_valid,
    input  logic                          wheel_ready,
    output mwm_pkg::rpm_set_t             mix_rpm
);

    localparam int STAGES = 6;
    localparam int CMP_W  = ((SPEED_WIDTH > mwm_pkg::LIM_W) ? SPEED_WIDTH : mwm_pkg::LIM_W) + 1;
    localparam int PW     = mwm_pkg::ACC_W - mwm_pkg::RPM_SHIFT;
    localparam int AX_FWD = 0;
    localparam int AX_LAT = 1;
    localparam int AX_YAW = 2;

    function automatic logic signed [mwm_pkg::VEL_W-1:0] clamp_speed(
        input logic signed [SPEED_WIDTH-1:0] v,
        input logic [mwm_pkg::LIM_W-1:0]     lim
    );
        logic signed [CMP_W-1:0] ve;
        logic signed [CMP_W-1:0] hi;
        logic signed [CMP_W-1:0] r;
        ve = CMP_W'(v);
        hi = $signed(CMP_W'(lim));
        if (ve > hi)
        begin
            r = hi;
        end
        else if (ve < -hi)
        begin
            r = -hi;
        end
        else
        begin
            r = ve;
        end
        return r[mwm_pkg::VEL_W-1:0];
    endfunction

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] load;

    logic signed [mwm_pkg::VEL_W-1:0] vel_next [3];
    logic signed [mwm_pkg::VEL_W-1:0] vel_reg  [3];
    logic signed [mwm_pkg::MIX_W-1:0] rot_next;
    logic signed [mwm_pkg::MIX_W-1:0] rot_reg;
    logic signed [mwm_pkg::SUM_W-1:0] sum_next [mwm_pkg::WHEELS];
    logic signed [mwm_pkg::SUM_W-1:0] sum_reg  [mwm_pkg::WHEELS];
    logic signed [mwm_pkg::MIX_W-1:0] mix_next [mwm_pkg::WHEELS];
    logic signed [mwm_pkg::MIX_W-1:0] mix_reg  [mwm_pkg::WHEELS];
    logic [mwm_pkg::MAG_W-1:0]        mag_next [mwm_pkg::WHEELS];
    logic [mwm_pkg::MAG_W-1:0]        mag_reg  [mwm_pkg::WHEELS];
    logic [mwm_pkg::WHEELS-1:0]       neg3_next;
    logic [mwm_pkg::WHEELS-1:0]       neg3_reg;
    logic [mwm_pkg::PP_W-1:0]         ph_next  [mwm_pkg::WHEELS];
    logic [mwm_pkg::PP_W-1:0]         ph_reg   [mwm_pkg::WHEELS];
    logic [mwm_pkg::PP_W-1:0]         pl_next  [mwm_pkg::WHEELS];
    logic [mwm_pkg::PP_W-1:0]         pl_reg   [mwm_pkg::WHEELS];
    logic [mwm_pkg::WHEELS-1:0]       neg4_reg;
    mwm_pkg::rpm_set_t                rpm_next;
    mwm_pkg::rpm_set_t                rpm_reg;

    // A stage loads when it is empty or when the stage after it loads.
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || wheel_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign cmd_ready   = load[0];
    assign wheel_valid = valid_reg[STAGES-1];
    assign mix_rpm     = rpm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= cmd_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [mwm_pkg::MIX_W-1:0] t;
        logic [mwm_pkg::ACC_W-1:0]        acc;
        logic [PW-1:0]                    p;
        logic [mwm_pkg::RPM_W-1:0]        plow;

        vel_next[AX_FWD] = clamp_speed(forward_speed, cfg.max_forward);
        vel_next[AX_LAT] = clamp_speed(lateral_speed, cfg.max_lateral);
        vel_next[AX_YAW] = clamp_speed(yaw_rate, cfg.max_yaw);

        rot_next = mwm_pkg::MIX_W'(vel_reg[AX_YAW])
                 * $signed(mwm_pkg::MIX_W'(cfg.rotate_ratio));
        sum_next[mwm_pkg::WHEEL_FR] = -mwm_pkg::SUM_W'(vel_reg[AX_FWD])
                                    - mwm_pkg::SUM_W'(vel_reg[AX_LAT]);
        sum_next[mwm_pkg::WHEEL_FL] =  mwm_pkg::SUM_W'(vel_reg[AX_FWD])
                                    - mwm_pkg::SUM_W'(vel_reg[AX_LAT]);
        sum_next[mwm_pkg::WHEEL_BL] =  mwm_pkg::SUM_W'(vel_reg[AX_FWD])
                                    + mwm_pkg::SUM_W'(vel_reg[AX_LAT]);
        sum_next[mwm_pkg::WHEEL_BR] = -mwm_pkg::SUM_W'(vel_reg[AX_FWD])
                                    + mwm_pkg::SUM_W'(vel_reg[AX_LAT]);

        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            mix_next[i] = (mwm_pkg::MIX_W'(sum_reg[i]) <<< mwm_pkg::ONE_SHIFT) - rot_reg;

            neg3_next[i] = mix_reg[i][mwm_pkg::MIX_W-1];
            t            = neg3_next[i] ? -mix_reg[i] : mix_reg[i];
            mag_next[i]  = t[mwm_pkg::MAG_W-1:0];

            ph_next[i] = mwm_pkg::PP_W'(mag_reg[i])
                       * mwm_pkg::PP_W'(cfg.rpm_ratio[mwm_pkg::RATIO_W-1:mwm_pkg::RATIO_SPLIT]);
            pl_next[i] = mwm_pkg::PP_W'(mag_reg[i])
                       * mwm_pkg::PP_W'(cfg.rpm_ratio[mwm_pkg::RATIO_SPLIT-1:0]);

            // Whole product over 2^40, truncated, then saturated to 16 bits.
            acc  = mwm_pkg::ACC_W'(ph_reg[i])
                 + mwm_pkg::ACC_W'(pl_reg[i] >> mwm_pkg::RATIO_SPLIT);
            p    = acc[mwm_pkg::ACC_W-1:mwm_pkg::RPM_SHIFT];
            plow = p[mwm_pkg::RPM_W-1:0];
            if (neg4_reg[i])
            begin
                rpm_next[i] = (p > PW'(mwm_pkg::RPM_MAX)) ? mwm_pkg::RPM_MIN : (~plow + 1'b1);
            end
            else
            begin
                rpm_next[i] = (p >= PW'(mwm_pkg::RPM_MAX)) ? mwm_pkg::RPM_MAX : plow;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            vel_reg <= vel_next;
        end
        if (load[1])
        begin
            rot_reg <= rot_next;
            sum_reg <= sum_next;
        end
        if (load[2])
        begin
            mix_reg <= mix_next;
        end
        if (load[3])
        begin
            mag_reg  <= mag_next;
            neg3_reg <= neg3_next;
        end
        if (load[4])
        begin
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            neg4_reg <= neg3_reg;
        end
        if (load[5])
        begin
            rpm_reg <= rpm_next;
        end
    end

endmodule

// File: rtl/mwm_limit.sv
module mwm_limit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mwm_pkg::LIM_W-1:0]   rpm_limit,
    input  logic                        wheel_valid,
    output logic                        wheel_ready,
    input  mwm_pkg::rpm_set_t           mix_rpm,
    output logic                        lim_valid,
    input  logic                        lim_ready,
    output mwm_pkg::lim_beat_t          lim_beat
);

    localparam int STAGES = 2;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] load;

    logic [mwm_pkg::ABS_W-1:0] abs_next  [mwm_pkg::WHEELS];
    logic [mwm_pkg::ABS_W-1:0] abs_reg   [mwm_pkg::WHEELS];
    logic [mwm_pkg::ABS_W-1:0] pmax_next [2];
    logic [mwm_pkg::ABS_W-1:0] pmax_reg  [2];
    mwm_pkg::rpm_set_t         rpm_reg;
    mwm_pkg::lim_beat_t        beat_next;
    mwm_pkg::lim_beat_t        beat_reg;

    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || lim_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign wheel_ready = load[0];
    assign lim_valid   = valid_reg[STAGES-1];
    assign lim_beat    = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= wheel_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        logic [mwm_pkg::RPM_W-1:0] w;
        logic [mwm_pkg::ABS_W-1:0] m;

        // Magnitudes; -32768 maps to 32768, which still fits unsigned.
        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            w           = mix_rpm[i];
            abs_next[i] = w[mwm_pkg::RPM_W-1] ? (~w + 1'b1) : w;
        end
        pmax_next[0] = (abs_next[0] > abs_next[1]) ? abs_next[0] : abs_next[1];
        pmax_next[1] = (abs_next[2] > abs_next[3]) ? abs_next[2] : abs_next[3];

        m = (pmax_reg[0] > pmax_reg[1]) ? pmax_reg[0] : pmax_reg[1];
        beat_next.rpm     = rpm_reg;
        beat_next.max_mag = m;
        beat_next.scaled  = m > mwm_pkg::ABS_W'(rpm_limit);
        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            beat_next.prod[i] = mwm_pkg::PROD_W'(abs_reg[i])
                              * mwm_pkg::PROD_W'(rpm_limit);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            abs_reg  <= abs_next;
            pmax_reg <= pmax_next;
            rpm_reg  <= mix_rpm;
        end
        if (load[1])
        begin
            beat_reg <= beat_next;
        end
    end

endmodule

// File: rtl/mwm_div.sv
module mwm_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               lim_valid,
    output logic               lim_ready,
    input  mwm_pkg::lim_beat_t lim_beat,
    output logic               rpm_valid,
    input  logic               rpm_ready,
    output mwm_pkg::result_t   result
);

    localparam int STAGES = mwm_pkg::DIV_STAGES + 1;

    // Per lane: partial remainder, and a register that shifts out the low
    // dividend bits while shifting in the quotient bits.
    typedef struct packed {
        logic [mwm_pkg::WHEELS-1:0][mwm_pkg::ABS_W-1:0] rem;
        logic [mwm_pkg::WHEELS-1:0][mwm_pkg::QUO_W-1:0] quo;
        logic [mwm_pkg::ABS_W-1:0]                      divisor;
        logic                                           scaled;
        mwm_pkg::rpm_set_t                              rpm;
    } div_stage_t;

    function automatic div_stage_t div_entry(input mwm_pkg::lim_beat_t b);
        div_stage_t r;
        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            r.rem[i] = b.prod[i][mwm_pkg::PROD_W-1:mwm_pkg::QUO_W];
            r.quo[i] = b.prod[i][mwm_pkg::QUO_W-1:0];
        end
        r.divisor = b.max_mag;
        r.scaled  = b.scaled;
        r.rpm     = b.rpm;
        return r;
    endfunction

    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t                r;
        logic [mwm_pkg::ABS_W:0]   trial;
        logic [mwm_pkg::ABS_W:0]   diff;
        r = s;
        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            trial = {s.rem[i], s.quo[i][mwm_pkg::QUO_W-1]};
            diff  = trial - {1'b0, s.divisor};
            if (trial >= {1'b0, s.divisor})
            begin
                r.rem[i] = diff[mwm_pkg::ABS_W-1:0];
                r.quo[i] = {s.quo[i][mwm_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                r.rem[i] = trial[mwm_pkg::ABS_W-1:0];
                r.quo[i] = {s.quo[i][mwm_pkg::QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] load;

    div_stage_t       stage_next [mwm_pkg::DIV_STAGES];
    div_stage_t       stage_reg  [mwm_pkg::DIV_STAGES];
    mwm_pkg::result_t res_next;
    mwm_pkg::result_t res_reg;

    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || rpm_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign lim_ready = load[0];
    assign rpm_valid = valid_reg[STAGES-1];
    assign result    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= lim_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (load[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        div_stage_t                cur;
        div_stage_t                last;
        logic [mwm_pkg::RPM_W-1:0] q;

        for (int k = 0; k < mwm_pkg::DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                cur = div_entry(lim_beat);
            end
            else
            begin
                cur = stage_reg[k-1];
            end
            for (int j = 0; j < mwm_pkg::DIV_STEPS; j++)
            begin
                if (k * mwm_pkg::DIV_STEPS + j < mwm_pkg::QUO_W)
                begin
                    cur = div_step(cur);
                end
            end
            stage_next[k] = cur;
        end

        // Magnitude quotient takes the wheel's sign, which truncates toward zero.
        last            = stage_reg[mwm_pkg::DIV_STAGES-1];
        res_next.scaled = last.scaled;
        for (int i = 0; i < mwm_pkg::WHEELS; i++)
        begin
            q = mwm_pkg::RPM_W'(last.quo[i]);
            if (!last.scaled)
            begin
                res_next.rpm[i] = last.rpm[i];
            end
            else if (last.rpm[i][mwm_pkg::RPM_W-1])
            begin
                res_next.rpm[i] = ~q + 1'b1;
            end
            else
            begin
                res_next.rpm[i] = q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < mwm_pkg::DIV_STAGES; k++)
        begin
            if (load[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
        if (load[STAGES-1])
        begin
            res_reg <= res_next;
        end
    end

endmodule

// File: rtl/mecanum_wheel_mixer.sv
// Mecanum wheel mixer: turns a chassis velocity command into four wheel speeds.
// Command channel (cmd_valid/cmd_ready) takes forward_speed, lateral_speed and
// yaw_rate; each beat yields exactly one beat on the result channel
// (rpm_valid/rpm_ready) with rpm_front_right, rpm_front_left, rpm_back_left,
// rpm_back_right and was_scaled, in command order.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// the six limit and ratio registers; cfg_ready is always high. Write them only
// while no command is in flight.
// From command beat to result beat each command passes through six mixing
// stages (clamp, rotation product, mix, magnitude, rpm partial products,
// rpm saturation), two limit stages (wheel maximum, limit product), five
// divider stages of three quotient bits each and the output register.
// Throughput is one command per cycle unless the receiver stalls; every stage is pipelined.
// Reset clears all stage valid bits and loads the register defaults.
// When the receiver stalls, the output register holds its beat; upstream
// stages keep filling any empty slots, and cmd_ready falls only once every
// stage holds a beat. No beat is dropped or repeated.
module mecanum_wheel_mixer #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mwm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  logic signed [SPEED_WIDTH-1:0]      forward_speed,
    input  logic signed [SPEED_WIDTH-1:0]      lateral_speed,
    input  logic signed [SPEED_WIDTH-1:0]      yaw_rate,
    output logic                               rpm_valid,
    input  logic                               rpm_ready,
    output logic signed [mwm_pkg::RPM_W-1:0]   rpm_front_right,
    output logic signed [mwm_pkg::RPM_W-1:0]   rpm_front_left,
    output logic signed [mwm_pkg::RPM_W-1:0]   rpm_back_left,
    output logic signed [mwm_pkg::RPM_W-1:0]   rpm_back_right,
    output logic                               was_scaled
);

    logic [mwm_pkg::LIM_W-1:0]   max_forward_reg;
    logic [mwm_pkg::LIM_W-1:0]   max_lateral_reg;
    logic [mwm_pkg::LIM_W-1:0]   max_yaw_reg;
    logic [mwm_pkg::LIM_W-1:0]   max_rpm_reg;
    logic [mwm_pkg::RATIO_W-1:0] rotate_ratio_reg;
    logic [mwm_pkg::RATIO_W-1:0] rpm_ratio_reg;
    mwm_pkg::cfg_t               cfg;

    logic                        wheel_valid;
    logic                        wheel_ready;
    mwm_pkg::rpm_set_t           mix_rpm;
    logic                        lim_valid;
    logic                        lim_ready;
    mwm_pkg::lim_beat_t          lim_beat;
    mwm_pkg::result_t            result;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    // Writes to an index past the last register are dropped, and data bits
    // above a register's width are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_forward_reg  <= mwm_pkg::RST_MAX_FORWARD;
            max_lateral_reg  <= mwm_pkg::RST_MAX_LATERAL;
            max_yaw_reg      <= mwm_pkg::RST_MAX_YAW;
            max_rpm_reg      <= mwm_pkg::RST_MAX_RPM;
            rotate_ratio_reg <= mwm_pkg::RST_ROTATE;
            rpm_ratio_reg    <= mwm_pkg::RST_RPM_RATIO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (mwm_pkg::cfg_index_t'(cfg_index))
                mwm_pkg::CFG_MAX_FORWARD:  max_forward_reg  <= cfg_data[mwm_pkg::LIM_W-1:0];
                mwm_pkg::CFG_MAX_LATERAL:  max_lateral_reg  <= cfg_data[mwm_pkg::LIM_W-1:0];
                mwm_pkg::CFG_MAX_YAW:      max_yaw_reg      <= cfg_data[mwm_pkg::LIM_W-1:0];
                mwm_pkg::CFG_MAX_RPM:      max_rpm_reg      <= cfg_data[mwm_pkg::LIM_W-1:0];
                mwm_pkg::CFG_ROTATE_RATIO: rotate_ratio_reg <= cfg_data[mwm_pkg::RATIO_W-1:0];
                mwm_pkg::CFG_RPM_RATIO:    rpm_ratio_reg    <= cfg_data[mwm_pkg::RATIO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.max_forward  = max_forward_reg;
        cfg.max_lateral  = max_lateral_reg;
        cfg.max_yaw      = max_yaw_reg;
        cfg.max_rpm      = max_rpm_reg;
        cfg.rotate_ratio = rotate_ratio_reg;
        cfg.rpm_ratio    = rpm_ratio_reg;
    end

    // Clamp, mix and convert the command into saturated wheel rpm.
    mwm_mix #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_mix (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .forward_speed (forward_speed),
        .lateral_speed (lateral_speed),
        .yaw_rate      (yaw_rate),
        .wheel_valid   (wheel_valid),
        .wheel_ready   (wheel_ready),
        .mix_rpm       (mix_rpm)
    );

    // Find the largest wheel magnitude and form the scaled numerators.
    mwm_limit u_limit (
        .clk         (clk),
        .rst_n       (rst_n),
        .rpm_limit   (cfg.max_rpm),
        .wheel_valid (wheel_valid),
        .wheel_ready (wheel_ready),
        .mix_rpm     (mix_rpm),
        .lim_valid   (lim_valid),
        .lim_ready   (lim_ready),
        .lim_beat    (lim_beat)
    );

    // Pipelined restoring divider for proportional limiting, plus output register.
    mwm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .lim_valid (lim_valid),
        .lim_ready (lim_ready),
        .lim_beat  (lim_beat),
        .rpm_valid (rpm_valid),
        .rpm_ready (rpm_ready),
        .result    (result)
    );

    assign rpm_front_right = result.rpm[mwm_pkg::WHEEL_FR];
    assign rpm_front_left  = result.rpm[mwm_pkg::WHEEL_FL];
    assign rpm_back_left   = result.rpm[mwm_pkg::WHEEL_BL];
    assign rpm_back_right  = result.rpm[mwm_pkg::WHEEL_BR];
    assign was_scaled      = result.scaled;

endmodule

// File: verif/mecanum_wheel_mixer_tb.sv
module mecanum_wheel_mixer_tb;

    import mwm_pkg::*;

    typedef logic signed [VEL_W-1:0] vel_t;

    // Two register indexes that decode to nothing. A write to either must leave
    // every register as it was.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam int CFG_REGS = CFG_RPM_RATIO + 1;

    // Random part: phases of commands, each under its own register settings.
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 117;

    // The long receiver hold starts once this many commands went in. It is far
    // longer than the pipeline is deep, so the block fills and drops cmd_ready.
    localparam int HOLD_AT     = 350;
    localparam int HOLD_CYCLES = 120;

    // The pipeline is 14 stages deep; the tail wait covers that with margin.
    localparam int TAIL_CYCLES = 40;

    // Cycles without any beat on any channel before the run is called hung.
    localparam int STALL_LIMIT = 2000;

    // One line of the directed script: either a register write or a command.
    // A command may carry its result written out by hand.
    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        vel_t                  fwd;
        vel_t                  lat;
        vel_t                  yaw;
        bit                    known;
        result_t               want;
    } script_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;
    logic                         cmd_valid = 1'b0;
    logic                         cmd_ready;
    vel_t                         forward_speed = '0;
    vel_t                         lateral_speed = '0;
    vel_t                         yaw_rate = '0;
    logic                         rpm_valid;
    logic                         rpm_ready = 1'b0;
    logic signed [RPM_W-1:0]      rpm_front_right;
    logic signed [RPM_W-1:0]      rpm_front_left;
    logic signed [RPM_W-1:0]      rpm_back_left;
    logic signed [RPM_W-1:0]      rpm_back_right;
    logic                         was_scaled;

    // A hand-written result travels with its command beat. These are driven
    // with nonblocking assignments together with the payload, so the checker
    // sees the values that belong to the beat being accepted.
    bit                           pin_on = 1'b0;
    result_t                      pin_want = '0;

    // Our own copy of the registers, updated on every accepted write beat.
    cfg_t chassis_cfg = '{
        max_forward:  RST_MAX_FORWARD,
        max_lateral:  RST_MAX_LATERAL,
        max_yaw:      RST_MAX_YAW,
        max_rpm:      RST_MAX_RPM,
        rotate_ratio: RST_ROTATE,
        rpm_ratio:    RST_RPM_RATIO
    };

    result_t     pending_wheels [$];
    int unsigned issued = 0;
    int unsigned delivered = 0;
    int unsigned faults = 0;
    int unsigned quiet_cycles = 0;
    bit          quiet_tail = 1'b0;
    bit          hold_done = 1'b0;

    string wheel_label [WHEELS] = '{"rpm_front_right", "rpm_front_left",
                                    "rpm_back_left", "rpm_back_right"};

    mecanum_wheel_mixer #(
        .SPEED_WIDTH (VEL_W)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .forward_speed   (forward_speed),
        .lateral_speed   (lateral_speed),
        .yaw_rate        (yaw_rate),
        .rpm_valid       (rpm_valid),
        .rpm_ready       (rpm_ready),
        .rpm_front_right (rpm_front_right),
        .rpm_front_left  (rpm_front_left),
        .rpm_back_left   (rpm_back_left),
        .rpm_back_right  (rpm_back_right),
        .was_scaled      (was_scaled)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Reset is asserted once from time zero and released on a clock edge.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Symmetric clamp of a speed to +/- its limit. A zero limit forces zero.
    function automatic longint clamp_speed(input vel_t v, input logic [LIM_W-1:0] lim);
        longint bound;
        bound = longint'(lim);
        if (longint'(v) > bound)
            return bound;
        if (longint'(v) < -bound)
            return -bound;
        return longint'(v);
    endfunction

    // Wheel speeds for one command under the given registers. The mix is done
    // in Q16 mm/s; the conversion to rpm multiplies by the Q0.24 ratio and
    // drops 40 fraction bits, truncating the magnitude. A wide product keeps
    // it exact. The proportional limit divides with truncation toward zero,
    // which is what signed integer division does here.
    function automatic result_t mix_wheels(input cfg_t c, input vel_t fwd, input vel_t lat,
                                           input vel_t yaw);
        longint    vx;
        longint    vy;
        longint    vw;
        longint    spin;
        longint    one;
        longint    peak;
        longint    q16 [WHEELS];
        longint    wheel [WHEELS];
        bit [79:0] mag;
        result_t   r;

        vx   = clamp_speed(fwd, c.max_forward);
        vy   = clamp_speed(lat, c.max_lateral);
        vw   = clamp_speed(yaw, c.max_yaw);
        one  = longint'(1) << ONE_SHIFT;
        spin = vw * longint'(c.rotate_ratio);

        q16[WHEEL_FR] = (-vx - vy) * one - spin;
        q16[WHEEL_FL] = ( vx - vy) * one - spin;
        q16[WHEEL_BL] = ( vx + vy) * one - spin;
        q16[WHEEL_BR] = (-vx + vy) * one - spin;

        peak = 0;
        for (int i = 0; i < WHEELS; i++)
        begin
            mag = (q16[i] < 0) ? -q16[i] : q16[i];
            mag = (mag * c.rpm_ratio) >> (ONE_SHIFT + RATIO_W);
            if (q16[i] < 0)
                wheel[i] = (mag >= 80'd32768) ? -32768 : -longint'(mag);
            else
                wheel[i] = (mag >= 80'd32767) ? 32767 : longint'(mag);
            if (wheel[i] > peak)
                peak = wheel[i];
            if (-wheel[i] > peak)
                peak = -wheel[i];
        end

        r.scaled = 1'b0;
        if (peak > longint'(c.max_rpm))
        begin
            r.scaled = 1'b1;
            for (int i = 0; i < WHEELS; i++)
                wheel[i] = wheel[i] * longint'(c.max_rpm) / peak;
        end
        for (int i = 0; i < WHEELS; i++)
            r.rpm[i] = RPM_W'(wheel[i]);
        return r;
    endfunction

    // Checker. Everything happens in this one block at the clock edge, so a
    // write, a command and a result in the same cycle are handled in a fixed
    // order. Commands get their expectation at acceptance, from the register
    // copy as it stands then; registers only change while nothing is in flight.
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        result_t seen;

        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_FORWARD:  chassis_cfg.max_forward  = cfg_data[LIM_W-1:0];
                    CFG_MAX_LATERAL:  chassis_cfg.max_lateral  = cfg_data[LIM_W-1:0];
                    CFG_MAX_YAW:      chassis_cfg.max_yaw      = cfg_data[LIM_W-1:0];
                    CFG_MAX_RPM:      chassis_cfg.max_rpm      = cfg_data[LIM_W-1:0];
                    CFG_ROTATE_RATIO: chassis_cfg.rotate_ratio = cfg_data[RATIO_W-1:0];
                    CFG_RPM_RATIO:    chassis_cfg.rpm_ratio    = cfg_data[RATIO_W-1:0];
                    default: ;
                endcase
            end

            if (cmd_valid && cmd_ready)
            begin
                if (pin_on)
                    pending_wheels.push_back(pin_want);
                else
                    pending_wheels.push_back(mix_wheels(chassis_cfg, forward_speed,
                                                        lateral_speed, yaw_rate));
            end

            if (rpm_valid && rpm_ready)
            begin
                delivered++;
                if (pending_wheels.size() == 0)
                begin
                    faults++;
                    $error("result beat arrived with no command outstanding");
                end
                else
                begin
                    want = pending_wheels.pop_front();
                    seen.rpm = {rpm_back_right, rpm_back_left, rpm_front_left, rpm_front_right};
                    seen.scaled = was_scaled;
                    for (int i = 0; i < WHEELS; i++)
                    begin
                        if (seen.rpm[i] !== want.rpm[i])
                        begin
                            faults++;
                            $error("%s: expected %0d, got %0d", wheel_label[i],
                                   $signed(want.rpm[i]), $signed(seen.rpm[i]));
                        end
                    end
                    if (seen.scaled !== want.scaled)
                    begin
                        faults++;
                        $error("was_scaled: expected %0d, got %0d", want.scaled, seen.scaled);
                    end
                end
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rpm_valid && rpm_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("mecanum_wheel_mixer regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side. Ready runs and stalls of random length follow one another in
    // random order. Once, well into the run, the receiver holds off for a
    // long stretch while the sender keeps offering, to back the pipeline up all
    // the way to cmd_ready. In the tail phase it never stalls.
    initial
    begin : receiver
        int n;

        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && issued >= HOLD_AT)
            begin
                hold_done = 1'b1;
                rpm_ready <= 1'b0;
                n = HOLD_CYCLES;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                rpm_ready <= 1'b0;
                n = $urandom_range(1, 5);
            end
            else
            begin
                rpm_ready <= 1'b1;
                n = $urandom_range(1, 20);
            end
            repeat (n) @(posedge clk);
        end
    end

    function automatic result_t wheels(input int fr, input int fl, input int bl, input int br,
                                       input bit scaled);
        result_t r;
        r.rpm[WHEEL_FR] = RPM_W'(fr);
        r.rpm[WHEEL_FL] = RPM_W'(fl);
        r.rpm[WHEEL_BL] = RPM_W'(bl);
        r.rpm[WHEEL_BR] = RPM_W'(br);
        r.scaled = scaled;
        return r;
    endfunction

    function automatic script_row_t command_row(input vel_t f, input vel_t l, input vel_t y);
        script_row_t row;
        row = '{default: '0};
        row.fwd = f;
        row.lat = l;
        row.yaw = y;
        return row;
    endfunction

    function automatic script_row_t known_row(input vel_t f, input vel_t l, input vel_t y,
                                              input result_t want);
        script_row_t row;
        row = command_row(f, l, y);
        row.known = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] index,
                                              input logic [CFG_DATA_W-1:0] value);
        script_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.reg_index = index;
        row.reg_value = value;
        return row;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] low_ones(input int width);
        return (CFG_DATA_W'(1) << width) - 1'b1;
    endfunction

    // A register value for a random phase: zero, all ones, the reset value,
    // something small or anything at all. Except with the reset value, bits above
    // the register width get random junk, which the block must drop.
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int width,
                                                           input logic [CFG_DATA_W-1:0] dflt);
        logic [CFG_DATA_W-1:0] ones;
        logic [CFG_DATA_W-1:0] junk;
        ones = low_ones(width);
        junk = CFG_DATA_W'($urandom) & ~ones;
        case ($urandom_range(0, 5))
            0:       return junk;
            1:       return ones | junk;
            2:       return dflt;
            3:       return CFG_DATA_W'($urandom_range(1, 64)) | junk;
            default: return (CFG_DATA_W'($urandom) & ones) | junk;
        endcase
    endfunction

    // A speed field for a random command: often the full 16-bit range, often
    // within the current clamp, sometimes right at an edge, sometimes small.
    function automatic vel_t pick_speed(input logic [LIM_W-1:0] lim);
        int span;
        span = int'(lim);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return vel_t'($urandom);
            4, 5, 6:    return vel_t'(int'($urandom_range(0, 2 * span)) - span);
            7:
            begin
                case ($urandom_range(0, 5))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return vel_t'(span);
                    3:       return vel_t'(-span);
                    4:       return vel_t'(span + 1);
                    default: return vel_t'(-span - 1);
                endcase
            end
            default:    return vel_t'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // Offers one command beat and returns at the edge where it is taken.
    // cmd_valid is left high; the caller lowers it only for a gap.
    task automatic offer_command(input vel_t f, input vel_t l, input vel_t y,
                                 input bit known, input result_t want);
        cmd_valid     <= 1'b1;
        forward_speed <= f;
        lateral_speed <= l;
        yaw_rate      <= y;
        pin_on        <= known;
        pin_want      <= want;
        do
            @(posedge clk);
        while (!cmd_ready);
        issued++;
    endtask

    // With odds out of eight, a sender gap of random length.
    task automatic maybe_pause(input int odds);
        if (!quiet_tail && odds != 0 && $urandom_range(1, 8) <= odds)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every command has produced its result,
    // which leaves the pipeline empty and the registers safe to change.
    task automatic settle();
        cmd_valid <= 1'b0;
        while (delivered != issued)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high so that back-to-back writes need no gap; the
    // caller lowers it after the last write of a group.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    initial
    begin : sender
        script_row_t           script [$];
        logic [CFG_DATA_W-1:0] reset_value [CFG_REGS];
        logic [CFG_DATA_W-1:0] setting;
        int                    width;
        int                    odds;

        reset_value = '{RST_MAX_FORWARD, RST_MAX_LATERAL, RST_MAX_YAW,
                        RST_MAX_RPM, RST_ROTATE, RST_RPM_RATIO};

        // Directed script. Under reset values a full forward command clamps
        // to 3300 mm/s, which is 21.8 rpm and truncates to 21 on each wheel.
        script.push_back(known_row(0, 0, 0, wheels(0, 0, 0, 0, 0)));
        script.push_back(known_row(16'sh7FFF, 0, 0, wheels(-21, 21, 21, -21, 0)));
        script.push_back(known_row(16'sh8000, 0, 0, wheels(21, -21, -21, 21, 0)));
        script.push_back(command_row(0, 16'sh7FFF, 0));
        script.push_back(command_row(0, 16'sh8000, 0));
        script.push_back(command_row(0, 0, 16'sh7FFF));
        script.push_back(command_row(0, 0, 16'sh8000));
        script.push_back(command_row(-1, -1, -1));

        // A zero forward limit forces the forward component to zero.
        script.push_back(write_row(CFG_MAX_FORWARD, 24'h0));
        script.push_back(known_row(1234, 0, 0, wheels(0, 0, 0, 0, 0)));

        // Everything wide open. Full forward plus full left drives the front
        // right and back left wheels past 16 bits, so both saturate; the peak
        // of 32768 is over the 32767 limit and all four are scaled.
        script.push_back(write_row(CFG_MAX_FORWARD, 24'h7FFF));
        script.push_back(write_row(CFG_MAX_LATERAL, 24'h7FFF));
        script.push_back(write_row(CFG_MAX_YAW, 24'h7FFF));
        script.push_back(write_row(CFG_RPM_RATIO, 24'hFFFFFF));
        script.push_back(write_row(CFG_MAX_RPM, 24'h7FFF));
        script.push_back(known_row(16'sh7FFF, 16'sh7FFF, 0, wheels(-32767, 0, 32766, 0, 1)));
        script.push_back(command_row(16'sh8000, 16'sh8000, 16'sh8000));
        script.push_back(command_row(12345, -321, 77));

        // With a zero rpm limit any nonzero wheel set collapses to zeros.
        script.push_back(write_row(CFG_MAX_RPM, 24'h0));
        script.push_back(known_row(100, 0, 0, wheels(0, 0, 0, 0, 1)));
        script.push_back(known_row(0, 0, 0, wheels(0, 0, 0, 0, 0)));

        // Writes to undecoded indexes must change nothing, and bits above a
        // register's width must be dropped: this sets the rpm limit to 100.
        script.push_back(write_row(CFG_UNUSED_LO, 24'h0));
        script.push_back(write_row(CFG_UNUSED_HI, 24'h0));
        script.push_back(write_row(CFG_MAX_RPM, 24'hFF8064));
        script.push_back(command_row(16'sh7FFF, 16'sh8000, 16'sh7FFF));

        // Rotation ratio at both ends.
        script.push_back(write_row(CFG_ROTATE_RATIO, 24'h0));
        script.push_back(known_row(0, 0, 500, wheels(0, 0, 0, 0, 0)));
        script.push_back(write_row(CFG_ROTATE_RATIO, 24'hFFFFFF));
        script.push_back(command_row(0, 0, 16'sh7FFF));
        script.push_back(command_row(0, 0, 16'sh8000));

        // A zero rpm ratio turns every command into zeros.
        script.push_back(write_row(CFG_RPM_RATIO, 24'h0));
        script.push_back(known_row(16'sh8000, 16'sh7FFF, 16'sh8000, wheels(0, 0, 0, 0, 0)));

        @(posedge rst_n);
        @(posedge clk);

        foreach (script[k])
        begin
            if (script[k].is_write)
            begin
                // A group of writes starts only once the pipeline is empty.
                if (k == 0 || !script[k-1].is_write)
                    settle();
                write_register(script[k].reg_index, script[k].reg_value);
                if (k + 1 == script.size() || !script[k+1].is_write)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                offer_command(script[k].fwd, script[k].lat, script[k].yaw,
                              script[k].known, script[k].want);
                maybe_pause(2);
            end
        end

        // Random phases. The first restores the reset values, the second
        // opens every register fully, the third pins the rpm limit at one so
        // nearly every command is scaled; the rest pick values at random. Each
        // phase begins with the sender paused until all results are back.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            for (int r = 0; r < CFG_REGS; r++)
            begin
                width = (r >= CFG_ROTATE_RATIO) ? RATIO_W : LIM_W;
                case (p)
                    0:       setting = reset_value[r];
                    1:       setting = low_ones(width);
                    2:       setting = (r == CFG_MAX_RPM) ? CFG_DATA_W'(1)
                                                          : pick_setting(width, reset_value[r]);
                    default: setting = pick_setting(width, reset_value[r]);
                endcase
                write_register(CFG_IDX_W'(r), setting);
            end
            write_register(($urandom_range(0, 1) == 0) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                           CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;

            // The last phase runs with no idling on either side; the others
            // each get their own gap density, zero included.
            quiet_tail = (p == PHASES - 1);
            odds = quiet_tail ? 0 : $urandom_range(0, 4);

            repeat (PHASE_ITEMS)
            begin
                offer_command(pick_speed(chassis_cfg.max_forward),
                              pick_speed(chassis_cfg.max_lateral),
                              pick_speed(chassis_cfg.max_yaw), 1'b0, '0);
                maybe_pause(odds);
            end
        end

        // Drain, then give the block time to show any stray extra beat.
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (faults == 0 && pending_wheels.size() == 0)
            $display("mecanum_wheel_mixer regression: pass");
        else
            $display("mecanum_wheel_mixer regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/mwm_pkg.sv
rtl/mwm_mix.sv
rtl/mwm_limit.sv
rtl/mwm_div.sv
rtl/mecanum_wheel_mixer.sv
verif/mecanum_wheel_mixer_tb.sv
